// ===== hdl/swtn_pkg.sv =====
// Shared types and constants of the top-4 skin weight normalizer.
`default_nettype none

package swtn_pkg;

    localparam int unsigned BONE_W    = 8;
    localparam int unsigned WEIGHT_W  = 16;
    localparam int unsigned OUT_SLOTS = 4;
    localparam int unsigned USED_W    = 3;

    // Influences whose bone index is not below this count are ignored.
    localparam int unsigned BONE_COUNT = 256;

    typedef enum logic [1:0] {
        OUTCOME_NORMALIZED = 2'd0,
        OUTCOME_NO_INFL    = 2'd1,
        OUTCOME_ZERO_SUM   = 2'd2
    } outcome_t;

endpackage

`default_nettype wire

// ===== hdl/swtn_front.sv =====
// Front end: accepts influences and keeps the heaviest ones in sorted order.
`default_nettype none

module swtn_front #(
    parameter int unsigned MAX_KEPT = 4,
    parameter int unsigned CNT_W    = 3
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          in_valid,
    output logic                                               in_ready,
    input  wire logic                                          has_weight,
    input  wire logic [swtn_pkg::BONE_W-1:0]                   bone_index,
    input  wire logic [swtn_pkg::WEIGHT_W-1:0]                 weight,
    input  wire logic                                          last_of_vertex,
    output logic                                               push_valid,
    input  wire logic                                          push_ready,
    output logic [CNT_W-1:0]                                   push_count,
    output logic [MAX_KEPT-1:0][swtn_pkg::BONE_W-1:0]          push_bones,
    output logic [MAX_KEPT-1:0][swtn_pkg::WEIGHT_W-1:0]        push_weights
);

    logic [MAX_KEPT-1:0]                             valid_reg;
    logic [MAX_KEPT-1:0][swtn_pkg::BONE_W-1:0]       bones_reg;
    logic [MAX_KEPT-1:0][swtn_pkg::WEIGHT_W-1:0]     weights_reg;

    logic [MAX_KEPT-1:0]                             valid_next;
    logic [MAX_KEPT-1:0][swtn_pkg::BONE_W-1:0]       bones_next;
    logic [MAX_KEPT-1:0][swtn_pkg::WEIGHT_W-1:0]     weights_next;
    logic [CNT_W-1:0]                                count_next;
    logic [CNT_W-1:0]                                pos;
    logic                                            take;
    logic                                            accept;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        take = has_weight && (17'(bone_index) < 17'(swtn_pkg::BONE_COUNT));

        // The kept list is sorted, so the slots not lighter than the new weight
        // form a prefix and their number is the insertion point.
        pos = '0;
        for (int i = 0; i < MAX_KEPT; i++)
        begin
            if (valid_reg[i] && (weights_reg[i] >= weight))
            begin
                pos = pos + CNT_W'(1);
            end
        end

        valid_next   = valid_reg;
        bones_next   = bones_reg;
        weights_next = weights_reg;
        if (take && (pos < CNT_W'(MAX_KEPT)))
        begin
            valid_next = MAX_KEPT'({valid_reg, 1'b1});
            for (int i = 1; i < MAX_KEPT; i++)
            begin
                if (CNT_W'(i) > pos)
                begin
                    bones_next[i]   = bones_reg[i-1];
                    weights_next[i] = weights_reg[i-1];
                end
            end
            for (int i = 0; i < MAX_KEPT; i++)
            begin
                if (CNT_W'(i) == pos)
                begin
                    bones_next[i]   = bone_index;
                    weights_next[i] = weight;
                end
            end
        end

        count_next = '0;
        for (int i = 0; i < MAX_KEPT; i++)
        begin
            count_next = count_next + CNT_W'(valid_next[i]);
        end
    end

    assign push_valid   = accept && last_of_vertex;
    assign push_count   = count_next;
    assign push_bones   = bones_next;
    assign push_weights = weights_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            bones_reg   <= '0;
            weights_reg <= '0;
        end
        else if (accept)
        begin
            if (last_of_vertex)
            begin
                // The vertex is handed to the back end; start the next one empty.
                valid_reg   <= '0;
                bones_reg   <= '0;
                weights_reg <= '0;
            end
            else
            begin
                valid_reg   <= valid_next;
                bones_reg   <= bones_next;
                weights_reg <= weights_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/swtn_fifo.sv =====
// Two-entry queue that carries finished kept sets from the front to the back end.
`default_nettype none

module swtn_fifo #(
    parameter int unsigned WIDTH = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);

    logic [1:0][WIDTH-1:0] mem_reg;
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            count_reg;
    logic                  do_wr;
    logic                  do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/swtn_back.sv =====
// Back end: sums a kept set and divides its weights in four bit-serial lanes.
`default_nettype none

module swtn_back #(
    parameter int unsigned MAX_KEPT         = 4,
    parameter int unsigned WEIGHT_FRAC_BITS = 15,
    parameter int unsigned CNT_W            = 3
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          set_valid,
    output logic                                               set_ready,
    input  wire logic [CNT_W-1:0]                              set_count,
    input  wire logic [MAX_KEPT-1:0][swtn_pkg::BONE_W-1:0]     set_bones,
    input  wire logic [MAX_KEPT-1:0][swtn_pkg::WEIGHT_W-1:0]   set_weights,
    output logic                                               out_valid,
    input  wire logic                                          out_ready,
    output logic [swtn_pkg::OUT_SLOTS-1:0][swtn_pkg::BONE_W-1:0]   out_bones,
    output logic [swtn_pkg::OUT_SLOTS-1:0][swtn_pkg::WEIGHT_W-1:0] out_weights,
    output logic [swtn_pkg::USED_W-1:0]                        out_used,
    output swtn_pkg::outcome_t                                 out_outcome
);

    localparam int unsigned SUM_W  = swtn_pkg::WEIGHT_W + $clog2(MAX_KEPT);
    localparam int unsigned R_W    = SUM_W + 1;
    localparam int unsigned Q_W    = WEIGHT_FRAC_BITS + 1;
    localparam int unsigned STEP_W = $clog2(Q_W);
    localparam int unsigned LANES  = swtn_pkg::OUT_SLOTS;
    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << WEIGHT_FRAC_BITS;
    // Default result weights: full weight in the first slot, zero elsewhere.
    localparam logic [LANES-1:0][swtn_pkg::WEIGHT_W-1:0] DEFAULT_WEIGHTS =
        {{((LANES - 1) * swtn_pkg::WEIGHT_W){1'b0}}, swtn_pkg::WEIGHT_W'(ONE_Q)};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                                       state_reg;
    logic [STEP_W-1:0]                            step_reg;
    logic [SUM_W-1:0]                             sum_reg;
    logic [CNT_W-1:0]                             cnt_reg;
    logic [LANES-1:0][R_W-1:0]                    rem_reg;
    logic [LANES-1:0][Q_W-1:0]                    quo_reg;
    logic [LANES-1:0][swtn_pkg::BONE_W-1:0]       bone_reg;

    logic                                         out_valid_reg;
    logic [LANES-1:0][swtn_pkg::BONE_W-1:0]       out_bones_reg;
    logic [LANES-1:0][swtn_pkg::WEIGHT_W-1:0]     out_weights_reg;
    logic [swtn_pkg::USED_W-1:0]                  out_used_reg;
    swtn_pkg::outcome_t                           out_outcome_reg;

    logic [LANES-1:0][swtn_pkg::BONE_W-1:0]       lane_bone;
    logic [LANES-1:0][swtn_pkg::WEIGHT_W-1:0]     lane_weight;
    logic [SUM_W-1:0]                             sum_in;
    logic [LANES-1:0][R_W-1:0]                    trial;
    logic [LANES-1:0]                             fits;
    logic [LANES-1:0][R_W-1:0]                    rem_next;
    logic [LANES-1:0][Q_W-1:0]                    quo_next;
    logic [swtn_pkg::USED_W-1:0]                  used_next;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        if (g < MAX_KEPT)
        begin : g_used
            assign lane_bone[g]   = set_bones[g];
            assign lane_weight[g] = set_weights[g];
        end
        else
        begin : g_empty
            assign lane_bone[g]   = '0;
            assign lane_weight[g] = '0;
        end
    end

    always_comb
    begin
        // Slots past the kept count hold zero, so every slot enters the sum.
        sum_in = '0;
        for (int j = 0; j < MAX_KEPT; j++)
        begin
            sum_in = sum_in + SUM_W'(set_weights[j]);
        end

        // Restoring division. The first step compares the weight itself, which
        // never exceeds the sum; the rest shift in the fraction zeros.
        for (int i = 0; i < LANES; i++)
        begin
            trial[i]    = (step_reg == '0) ? rem_reg[i] : {rem_reg[i][R_W-2:0], 1'b0};
            fits[i]     = (trial[i] >= {1'b0, sum_reg});
            rem_next[i] = fits[i] ? (trial[i] - {1'b0, sum_reg}) : trial[i];
            quo_next[i] = {quo_reg[i][Q_W-2:0], fits[i]};
        end

        if (32'(cnt_reg) > LANES)
        begin
            used_next = swtn_pkg::USED_W'(LANES);
        end
        else
        begin
            used_next = swtn_pkg::USED_W'(cnt_reg);
        end
    end

    assign set_ready   = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_bones   = out_bones_reg;
    assign out_weights = out_weights_reg;
    assign out_used    = out_used_reg;
    assign out_outcome = out_outcome_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            sum_reg         <= '0;
            cnt_reg         <= '0;
            rem_reg         <= '0;
            quo_reg         <= '0;
            bone_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_bones_reg   <= '0;
            out_weights_reg <= '0;
            out_used_reg    <= '0;
            out_outcome_reg <= swtn_pkg::OUTCOME_NORMALIZED;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (set_valid)
                    begin
                        sum_reg  <= sum_in;
                        cnt_reg  <= set_count;
                        step_reg <= '0;
                        bone_reg <= lane_bone;
                        for (int i = 0; i < LANES; i++)
                        begin
                            rem_reg[i] <= R_W'(lane_weight[i]);
                        end
                        if ((set_count == '0) || (sum_in == '0))
                        begin
                            // Default result: bone 0 at full weight.
                            out_bones_reg      <= '0;
                            out_weights_reg    <= DEFAULT_WEIGHTS;
                            out_used_reg       <= '0;
                            out_outcome_reg    <= (set_count == '0) ?
                                                  swtn_pkg::OUTCOME_NO_INFL :
                                                  swtn_pkg::OUTCOME_ZERO_SUM;
                            out_valid_reg      <= 1'b1;
                            state_reg          <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    rem_reg  <= rem_next;
                    quo_reg  <= quo_next;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(Q_W - 1))
                    begin
                        out_bones_reg <= bone_reg;
                        for (int i = 0; i < LANES; i++)
                        begin
                            out_weights_reg[i] <= swtn_pkg::WEIGHT_W'(quo_next[i]);
                        end
                        out_used_reg    <= used_next;
                        out_outcome_reg <= swtn_pkg::OUTCOME_NORMALIZED;
                        out_valid_reg   <= 1'b1;
                        state_reg       <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/skin_weight_top4_normalizer_core.sv =====
// Top level of the top-4 skin weight selector and normalizer.
//
// Usage: the input channel (in_valid/in_ready) takes one bone influence per
// transaction; last_of_vertex closes the vertex. The output channel
// (out_valid/out_ready) delivers one transaction per closed vertex with up to
// four bones, heaviest first, and their weights divided by the kept sum.
// Throughput: the front end takes one influence per cycle while the queue has
// room. Each vertex then occupies the back end for the bit-serial division,
// whose lanes work on all four slots at once, until its result is taken. A
// vertex that falls back to the default result skips the division there.
// Results: a normalized result is registered when the last divide step ends;
// a default result is registered straight from the kept set, with no division.
// A two-entry queue between front and back lets the front keep collecting
// influences while the back end divides or its result waits.
// Stall: while out_ready is low the result holds; once the queue is full too,
// in_ready drops until the back end takes the next kept set.
// Reset: clears the kept set, empties the queue and drops out_valid.
`default_nettype none

module skin_weight_top4_normalizer_core #(
    parameter int unsigned MAX_KEPT         = 4,
    parameter int unsigned WEIGHT_FRAC_BITS = 15
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            has_weight,
    input  wire logic [swtn_pkg::BONE_W-1:0]     bone_index,
    input  wire logic [swtn_pkg::WEIGHT_W-1:0]   weight,
    input  wire logic                            last_of_vertex,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [swtn_pkg::BONE_W-1:0]          bone_id_a,
    output logic [swtn_pkg::BONE_W-1:0]          bone_id_b,
    output logic [swtn_pkg::BONE_W-1:0]          bone_id_c,
    output logic [swtn_pkg::BONE_W-1:0]          bone_id_d,
    output logic [swtn_pkg::WEIGHT_W-1:0]        norm_weight_a,
    output logic [swtn_pkg::WEIGHT_W-1:0]        norm_weight_b,
    output logic [swtn_pkg::WEIGHT_W-1:0]        norm_weight_c,
    output logic [swtn_pkg::WEIGHT_W-1:0]        norm_weight_d,
    output logic [swtn_pkg::USED_W-1:0]          used_slots,
    output logic [1:0]                           outcome
);

    localparam int unsigned CNT_W   = $clog2(MAX_KEPT + 1);
    localparam int unsigned ENTRY_W = CNT_W + MAX_KEPT * (swtn_pkg::BONE_W + swtn_pkg::WEIGHT_W);

    logic                                               push_valid;
    logic                                               push_ready;
    logic [CNT_W-1:0]                                   push_count;
    logic [MAX_KEPT-1:0][swtn_pkg::BONE_W-1:0]          push_bones;
    logic [MAX_KEPT-1:0][swtn_pkg::WEIGHT_W-1:0]        push_weights;

    logic                                               set_valid;
    logic                                               set_ready;
    logic [ENTRY_W-1:0]                                 set_entry;
    logic [CNT_W-1:0]                                   set_count;
    logic [MAX_KEPT-1:0][swtn_pkg::BONE_W-1:0]          set_bones;
    logic [MAX_KEPT-1:0][swtn_pkg::WEIGHT_W-1:0]        set_weights;

    logic [swtn_pkg::OUT_SLOTS-1:0][swtn_pkg::BONE_W-1:0]   out_bones;
    logic [swtn_pkg::OUT_SLOTS-1:0][swtn_pkg::WEIGHT_W-1:0] out_weights;
    swtn_pkg::outcome_t                                      out_outcome;

    swtn_front #(
        .MAX_KEPT (MAX_KEPT),
        .CNT_W    (CNT_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .has_weight     (has_weight),
        .bone_index     (bone_index),
        .weight         (weight),
        .last_of_vertex (last_of_vertex),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_count     (push_count),
        .push_bones     (push_bones),
        .push_weights   (push_weights)
    );

    swtn_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  ({push_count, push_bones, push_weights}),
        .rd_valid (set_valid),
        .rd_ready (set_ready),
        .rd_data  (set_entry)
    );

    assign {set_count, set_bones, set_weights} = set_entry;

    swtn_back #(
        .MAX_KEPT         (MAX_KEPT),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
        .CNT_W            (CNT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .set_valid   (set_valid),
        .set_ready   (set_ready),
        .set_count   (set_count),
        .set_bones   (set_bones),
        .set_weights (set_weights),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_bones   (out_bones),
        .out_weights (out_weights),
        .out_used    (used_slots),
        .out_outcome (out_outcome)
    );

    assign bone_id_a     = out_bones[0];
    assign bone_id_b     = out_bones[1];
    assign bone_id_c     = out_bones[2];
    assign bone_id_d     = out_bones[3];
    assign norm_weight_a = out_weights[0];
    assign norm_weight_b = out_weights[1];
    assign norm_weight_c = out_weights[2];
    assign norm_weight_d = out_weights[3];
    assign outcome       = out_outcome;

    // The back end takes a kept set only while no result is waiting.
    a_pop_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        set_valid && set_ready |-> !out_valid)
        else $error("kept set taken while a result is still pending");

    // A normalized result always reports at least one slot, never more than kept.
    a_used_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome == swtn_pkg::OUTCOME_NORMALIZED) |->
        (used_slots != '0) && (32'(used_slots) <= MAX_KEPT))
        else $error("normalized result with bad slot count");

    // A default result names bone 0 alone and leaves the other slots empty.
    a_default_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome != swtn_pkg::OUTCOME_NORMALIZED) |->
        (used_slots == '0) && (bone_id_a == '0) && (norm_weight_b == '0) &&
        (norm_weight_c == '0) && (norm_weight_d == '0))
        else $error("default result with nonempty slots");

endmodule

`default_nettype wire

// ===== tb/sv/skin_weight_top4_normalizer_checker.sv =====
// Watches both channels of the skin weight normalizer, predicts each result and compares.
module skin_weight_top4_normalizer_checker
    import swtn_pkg::*;
#(
    parameter int unsigned KEEP_DEPTH  = 4,
    parameter int unsigned WEIGHT_FRAC = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                has_weight,
    input  logic [BONE_W-1:0]   bone_index,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic                last_of_vertex,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [BONE_W-1:0]   bone_id_a,
    input  logic [BONE_W-1:0]   bone_id_b,
    input  logic [BONE_W-1:0]   bone_id_c,
    input  logic [BONE_W-1:0]   bone_id_d,
    input  logic [WEIGHT_W-1:0] norm_weight_a,
    input  logic [WEIGHT_W-1:0] norm_weight_b,
    input  logic [WEIGHT_W-1:0] norm_weight_c,
    input  logic [WEIGHT_W-1:0] norm_weight_d,
    input  logic [USED_W-1:0]   used_slots,
    input  logic [1:0]          outcome,
    output int                  fail_count,
    output int                  pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OUT_SLOTS-1:0][BONE_W-1:0]   bone;
        logic [OUT_SLOTS-1:0][WEIGHT_W-1:0] wgt;
        logic [USED_W-1:0]                  used;
        outcome_t                           result_kind;
    } vertex_result_t;

    logic [BONE_W-1:0]   held_bone [KEEP_DEPTH];
    logic [WEIGHT_W-1:0] held_wgt  [KEEP_DEPTH];
    int                  held_count;
    vertex_result_t      expected_vertices [$];
    int                  mismatch_count = 0;

    assign fail_count = mismatch_count;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic clear_held();
        int i;
        for (i = 0; i < KEEP_DEPTH; i++)
        begin
            held_bone[i] = '0;
            held_wgt[i]  = '0;
        end
        held_count = 0;
    endtask

    // Sorted insert, heaviest first; equal weights keep arrival order.
    task automatic keep_influence(input logic [BONE_W-1:0] b, input logic [WEIGHT_W-1:0] w);
        int pos;
        int i;
        pos = 0;
        while (pos < held_count && held_wgt[pos] >= w)
            pos++;
        if (pos < KEEP_DEPTH)
        begin
            if (held_count < KEEP_DEPTH)
                held_count++;
            for (i = held_count - 1; i > pos; i--)
            begin
                held_bone[i] = held_bone[i-1];
                held_wgt[i]  = held_wgt[i-1];
            end
            held_bone[pos] = b;
            held_wgt[pos]  = w;
        end
    endtask

    task automatic close_vertex();
        vertex_result_t res;
        longint unsigned total;
        longint unsigned quotient;
        int i;
        res   = '0;
        total = 0;
        for (i = 0; i < held_count; i++)
            total += held_wgt[i];
        if (held_count == 0 || total == 0)
        begin
            res.wgt[0]      = WEIGHT_W'(64'd1 << WEIGHT_FRAC);
            res.used        = '0;
            res.result_kind = (held_count == 0) ? OUTCOME_NO_INFL : OUTCOME_ZERO_SUM;
        end
        else
        begin
            for (i = 0; i < held_count && i < OUT_SLOTS; i++)
            begin
                quotient   = (longint'(held_wgt[i]) << WEIGHT_FRAC) / total;
                res.bone[i] = held_bone[i];
                res.wgt[i]  = quotient[WEIGHT_W-1:0];
                res.used    = res.used + USED_W'(1);
            end
            res.result_kind = OUTCOME_NORMALIZED;
        end
        expected_vertices = {expected_vertices, res};
        clear_held();
    endtask

    task automatic check_result();
        vertex_result_t want;
        logic [OUT_SLOTS-1:0][BONE_W-1:0]   got_bone;
        logic [OUT_SLOTS-1:0][WEIGHT_W-1:0] got_wgt;
        int i;
        got_bone = {bone_id_d, bone_id_c, bone_id_b, bone_id_a};
        got_wgt  = {norm_weight_d, norm_weight_c, norm_weight_b, norm_weight_a};
        if (expected_vertices.size() == 0)
        begin
            report_mismatch("result with no vertex pending", used_slots, 0);
            return;
        end
        want = expected_vertices.pop_front();
        for (i = 0; i < OUT_SLOTS; i++)
        begin
            if (got_bone[i] !== want.bone[i])
                report_mismatch($sformatf("bone_id slot %0d", i), got_bone[i], want.bone[i]);
            if (got_wgt[i] !== want.wgt[i])
                report_mismatch($sformatf("norm_weight slot %0d", i), got_wgt[i], want.wgt[i]);
        end
        if (used_slots !== want.used)
            report_mismatch("used_slots", used_slots, want.used);
        if (outcome !== want.result_kind)
            report_mismatch("outcome", outcome, want.result_kind);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_held();
            expected_vertices.delete();
            pending_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
            begin
                if (has_weight && int'(bone_index) < BONE_COUNT)
                    keep_influence(bone_index, weight);
                if (last_of_vertex)
                    close_vertex();
            end
            pending_count <= expected_vertices.size();
        end
    end

endmodule

// ===== tb/sv/skin_weight_top4_normalizer_core_test.sv =====
// Stimulus, handshake pacing and verdict for the skin weight normalizer core.
module skin_weight_top4_normalizer_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import swtn_pkg::*;

    localparam int TOTAL_ITEMS = 950;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                has_weight = 1'b0;
    logic [BONE_W-1:0]   bone_index = '0;
    logic [WEIGHT_W-1:0] weight = '0;
    logic                last_of_vertex = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [BONE_W-1:0]   bone_id_a, bone_id_b, bone_id_c, bone_id_d;
    logic [WEIGHT_W-1:0] norm_weight_a, norm_weight_b, norm_weight_c, norm_weight_d;
    logic [USED_W-1:0]   used_slots;
    logic [1:0]          outcome;

    int fail_count;
    int pending_count;
    int items_sent    = 0;
    int send_idle_pct = 20;
    int recv_idle_pct = 75;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    skin_weight_top4_normalizer_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .has_weight     (has_weight),
        .bone_index     (bone_index),
        .weight         (weight),
        .last_of_vertex (last_of_vertex),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .bone_id_a      (bone_id_a),
        .bone_id_b      (bone_id_b),
        .bone_id_c      (bone_id_c),
        .bone_id_d      (bone_id_d),
        .norm_weight_a  (norm_weight_a),
        .norm_weight_b  (norm_weight_b),
        .norm_weight_c  (norm_weight_c),
        .norm_weight_d  (norm_weight_d),
        .used_slots     (used_slots),
        .outcome        (outcome)
    );

    skin_weight_top4_normalizer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .has_weight     (has_weight),
        .bone_index     (bone_index),
        .weight         (weight),
        .last_of_vertex (last_of_vertex),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .bone_id_a      (bone_id_a),
        .bone_id_b      (bone_id_b),
        .bone_id_c      (bone_id_c),
        .bone_id_d      (bone_id_d),
        .norm_weight_a  (norm_weight_a),
        .norm_weight_b  (norm_weight_b),
        .norm_weight_c  (norm_weight_c),
        .norm_weight_d  (norm_weight_d),
        .used_slots     (used_slots),
        .outcome        (outcome),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: random back-pressure, plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else if (holds_served < hold_requests)
        begin
            holds_served++;
            hold_left = LONG_HOLD;
            out_ready = 1'b0;
        end
        else
            out_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Returns in the time step of the rising edge that accepted the transaction.
    task automatic send_item(input logic h, input logic [BONE_W-1:0] b,
                             input logic [WEIGHT_W-1:0] w, input logic l);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid       = 1'b1;
        has_weight     = h;
        bone_index     = b;
        weight         = w;
        last_of_vertex = l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    // Mix of full-range values, the extremes and small sets that force ties.
    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(9))
            0: return '0;
            1: return 16'd32768;
            2: return WEIGHT_W'($urandom_range(1, 4));
            3: return ($urandom_range(1) == 1) ? 16'd4096 : 16'd1000;
            default: return WEIGHT_W'($urandom_range(32768));
        endcase
    endfunction

    task automatic send_vertex();
        int r;
        int n;
        int i;
        logic close_apart;
        r = $urandom_range(99);
        if (r < 8)
            n = 0;
        else if (r < 75)
            n = $urandom_range(1, 4);
        else
            n = $urandom_range(5, 8);
        close_apart = ($urandom_range(5) == 0);
        if (n == 0)
        begin
            send_item(1'b0, BONE_W'($urandom_range(255)), pick_weight(), 1'b1);
            return;
        end
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(11) == 0)
                send_item(1'b0, BONE_W'($urandom_range(255)), pick_weight(), 1'b0);
            send_item(1'b1, BONE_W'($urandom_range(255)), pick_weight(),
                      !close_apart && i == n - 1);
        end
        if (close_apart)
            send_item(1'b0, BONE_W'($urandom_range(255)), pick_weight(), 1'b1);
    endtask

    task automatic send_vertices_until(input int target);
        while (items_sent < target)
            send_vertex();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Vertex with no influence at all.
        send_item(1'b0, 8'hA5, 16'h5A5A, 1'b1);
        // Single full-weight influence on the top bone index.
        send_item(1'b1, 8'd255, 16'd32768, 1'b1);
        // Only zero weights: the default bone comes back with a zero-sum outcome.
        send_item(1'b1, 8'd0, 16'd0, 1'b0);
        send_item(1'b1, 8'd7, 16'd0, 1'b1);
        // Ties keep arrival order; the lightest drops once the set is full,
        // and an item with no weight closes the vertex.
        send_item(1'b1, 8'd10, 16'd200, 1'b0);
        send_item(1'b1, 8'd11, 16'd100, 1'b0);
        send_item(1'b1, 8'd12, 16'd200, 1'b0);
        send_item(1'b1, 8'd13, 16'd300, 1'b0);
        send_item(1'b1, 8'd14, 16'd200, 1'b0);
        send_item(1'b1, 8'd15, 16'd50, 1'b0);
        send_item(1'b0, 8'd99, 16'd777, 1'b1);
        // A fifth influence equal to the lightest kept one is dropped.
        send_item(1'b1, 8'd1, 16'd500, 1'b0);
        send_item(1'b1, 8'd2, 16'd500, 1'b0);
        send_item(1'b1, 8'd3, 16'd500, 1'b0);
        send_item(1'b1, 8'd4, 16'd500, 1'b0);
        send_item(1'b1, 8'd5, 16'd500, 1'b1);
        // A zero weight kept beside a nonzero one normalizes to zero.
        send_item(1'b1, 8'd0, 16'd0, 1'b0);
        send_item(1'b1, 8'd200, 16'd32767, 1'b1);
        // Four full-weight influences: the largest sum that the stimulus reaches.
        send_item(1'b1, 8'd128, 16'd32768, 1'b0);
        send_item(1'b1, 8'd64, 16'd32768, 1'b0);
        send_item(1'b1, 8'd32, 16'd32768, 1'b0);
        send_item(1'b1, 8'd16, 16'd32768, 1'b1);
        wait_drained();

        send_vertices_until(350);
        wait_drained();

        send_idle_pct = 75;
        recv_idle_pct = 20;
        send_vertices_until(650);
        wait_drained();

        // No idling; a long hold-off on results fills the block while items keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_vertices_until(items_sent + 40);
        hold_requests++;
        send_vertices_until(TOTAL_ITEMS);
        wait_drained();

        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/swtn_pkg.sv
hdl/swtn_front.sv
hdl/swtn_fifo.sv
hdl/swtn_back.sv
hdl/skin_weight_top4_normalizer_core.sv
tb/sv/skin_weight_top4_normalizer_checker.sv
tb/sv/skin_weight_top4_normalizer_core_test.sv
